// ===== rtl/core/masked_byte_signature_scan_defines.svh =====
// ----------------------------------------------------------------------------
// masked_byte_signature_scan_defines
// assertion macros shared by the scanner modules
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_SIGNATURE_SCAN_DEFINES_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_DEFINES_SVH

`ifndef SYNTHESIS

`define MBSS_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("mbss assertion failed");

`define MBSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbss assertion failed");

`define MBSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbss assertion failed");

`else

`define MBSS_ASSERT(label, clk, rst, expr)

`define MBSS_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define MBSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/mbss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_pkg
// shared types, constants and helpers of the masked byte signature scanner
// ----------------------------------------------------------------------------
package mbss_pkg;

  localparam int PATTERN_MAX    = 16;
  localparam int RIP_OFFSET_MAX = 15;
  localparam int WINDOW_DEPTH   = 19;
  localparam int PAT_BYTES      = 16;
  localparam int DISP_BYTES     = 4;

  localparam int LEN_CAP_A = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int LEN_CAP   = (LEN_CAP_A < WINDOW_DEPTH) ? LEN_CAP_A : WINDOW_DEPTH;

  localparam int LEN_W   = 5;
  localparam int AGE_W   = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = 32;
  localparam int MATCH_W = 16;
  localparam int ADDR_W  = 64;
  localparam int DISP_W  = 8 * DISP_BYTES;
  localparam int REL_W   = CNT_W + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIP_OFFSET   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INSN_LEN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES  = 3'd7;

  typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;
  typedef logic [WINDOW_DEPTH-1:0]      flags_t;

  typedef struct packed {
    logic [63:0]        pattern_low;
    logic [63:0]        pattern_high;
    logic [15:0]        pattern_mask;
    logic [LEN_W-1:0]   pattern_len;
    logic [ADDR_W-1:0]  base_address;
    logic signed [4:0]  rip_offset;
    logic [3:0]         insn_len;
    logic [MATCH_W-1:0] max_matches;
  } cfg_t;

  typedef struct packed {
    flags_t           mask;
    flags_t           tmask;
    logic [CNT_W-1:0] n;
    window_t          win;
    logic             last;
  } run_t;

  typedef struct packed {
    logic load;
    logic end_empty;
    run_t run;
  } handoff_t;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  offset;
    logic [DISP_W-1:0] disp;
    logic              has_target;
    logic              last;
  } pick_t;

  function automatic logic rip_enabled(cfg_t c);
    logic ok;
    ok = !c.rip_offset[4] && (c.insn_len != '0)
         && (int'(c.rip_offset[3:0]) <= RIP_OFFSET_MAX)
         && (int'(c.rip_offset[3:0]) + DISP_BYTES <= WINDOW_DEPTH);
    return ok;
  endfunction

  function automatic logic [AGE_W-1:0] rip_value(cfg_t c);
    return AGE_W'(c.rip_offset[3:0]);
  endfunction

endpackage

// ===== rtl/core/masked_byte_signature_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_signature_scan
// masked byte pattern search over a byte stream with displacement resolution
// ----------------------------------------------------------------------------
// Bytes enter on the byte channel (data_byte, last_byte) and match reports
// leave on the match channel; both use valid and stall, a transaction taking
// place on a clock edge with valid high and stall low. Registers are written
// through cfg_write, cfg_index and cfg_data only while the block is idle, a
// rule for the user that the block does not enforce. A byte is taken every
// cycle while each byte releases at most one match and the output does not
// stall. A byte that releases k matches (stream end, register change)
// stalls the byte channel while the sequencer emits them, one match per
// cycle unless the output stalls, and drops those past the limit. Matches
// are registered in the sequencer, at the offset/displacement sum and at
// the address adders. A stalled output holds its report; the two inner
// stages then fill and the byte channel stalls. Reset loads the register
// defaults and clears the window, the pending flags and both counters.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mbss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 byte_valid,
  output logic                                 byte_stall,
  input  logic [7:0]                           data_byte,
  input  logic                                 last_byte,
  output logic                                 match_valid,
  input  logic                                 match_stall,
  output logic [mbss_pkg::CNT_W-1:0]           match_offset,
  output logic [mbss_pkg::ADDR_W-1:0]          match_address,
  output logic                                 has_target,
  output logic signed [mbss_pkg::DISP_W-1:0]   displacement,
  output logic [mbss_pkg::ADDR_W-1:0]          target_address,
  output logic                                 last_of_run
);
  import mbss_pkg::*;

  cfg_t     cfg;
  handoff_t handoff;
  pick_t    pick;
  logic     pick_ready;
  logic     run_free;
  logic     accept;

  assign byte_stall = !run_free;
  assign accept     = byte_valid && run_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low  <= '0;
      cfg.pattern_high <= '0;
      cfg.pattern_mask <= '1;
      cfg.pattern_len  <= LEN_W'(1);
      cfg.base_address <= '0;
      cfg.rip_offset   <= '1;
      cfg.insn_len     <= '0;
      cfg.max_matches  <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PATTERN_LOW:  cfg.pattern_low  <= cfg_data;
        CFG_PATTERN_HIGH: cfg.pattern_high <= cfg_data;
        CFG_PATTERN_MASK: cfg.pattern_mask <= cfg_data[15:0];
        CFG_PATTERN_LEN:  cfg.pattern_len  <= cfg_data[LEN_W-1:0];
        CFG_BASE_ADDRESS: cfg.base_address <= cfg_data[ADDR_W-1:0];
        CFG_RIP_OFFSET:   cfg.rip_offset   <= cfg_data[4:0];
        CFG_INSN_LEN:     cfg.insn_len     <= cfg_data[3:0];
        CFG_MAX_MATCHES:  cfg.max_matches  <= cfg_data[MATCH_W-1:0];
        default: ;
      endcase
    end
  end

  mbss_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .handoff   (handoff)
  );

  mbss_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .handoff    (handoff),
    .pick_ready (pick_ready),
    .run_free   (run_free),
    .pick       (pick)
  );

  mbss_result u_result (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .pick           (pick),
    .pick_ready     (pick_ready),
    .match_valid    (match_valid),
    .match_stall    (match_stall),
    .match_offset   (match_offset),
    .match_address  (match_address),
    .has_target     (has_target),
    .displacement   (displacement),
    .target_address (target_address),
    .last_of_run    (last_of_run)
  );

endmodule

// ===== rtl/core/mbss_scan.sv =====
`timescale 1ns / 1ps
`include "masked_byte_signature_scan_defines.svh"
// ----------------------------------------------------------------------------
// mbss_scan
// byte window, masked compare and pending match flags for one stream
// ----------------------------------------------------------------------------
module mbss_scan (
  input  logic              clk,
  input  logic              rst,
  input  mbss_pkg::cfg_t    cfg,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output mbss_pkg::handoff_t handoff
);
  import mbss_pkg::*;

  window_t          window;
  flags_t           flags;
  logic [CNT_W-1:0] byte_count;

  window_t          window_next;
  flags_t           flags_next;
  logic [CNT_W-1:0] byte_count_next;

  logic [PAT_BYTES-1:0][7:0] pat;
  logic [LEN_W-1:0] len;
  logic [AGE_W-1:0] len_m1;
  logic [AGE_W-1:0] rip3;
  logic [AGE_W-1:0] delay;
  logic             rip_en;
  logic             full;
  logic             count_ok;
  logic             hit;
  window_t          win_sh;
  flags_t           flg_sh;
  flags_t           flg_new;
  flags_t           due;
  flags_t           emit_mask;
  flags_t           tgt_mask;

  assign pat      = {cfg.pattern_high, cfg.pattern_low};
  assign len      = (cfg.pattern_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : cfg.pattern_len;
  assign len_m1   = (len != '0) ? AGE_W'(len) - AGE_W'(1) : '0;
  assign rip_en   = rip_enabled(cfg);
  assign rip3     = rip_value(cfg) + AGE_W'(DISP_BYTES - 1);
  assign delay    = (rip_en && (rip3 > len_m1)) ? rip3 : len_m1;
  assign full     = (byte_count == '1);
  assign count_ok = ({1'b0, byte_count} + (CNT_W+1)'(1)) >= (CNT_W+1)'(len);

  assign win_sh = {window[WINDOW_DEPTH-2:0], data_byte};
  assign flg_sh = {flags[WINDOW_DEPTH-2:0], 1'b0};

  // masked compare against the newest len bytes
  always_comb begin
    logic [AGE_W-1:0] idx;
    hit = count_ok && (len != '0);
    for (int j = 0; j < LEN_CAP; j++) begin
      idx = AGE_W'(len) - AGE_W'(j) - AGE_W'(1);
      if ((LEN_W'(j) < len) && cfg.pattern_mask[j] && (win_sh[idx] != pat[j])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    flg_new = flg_sh;
    if (hit) begin
      flg_new[len_m1] = 1'b1;
    end
    for (int a = 0; a < WINDOW_DEPTH; a++) begin
      due[a] = (AGE_W'(a) >= delay);
    end
  end

  always_comb begin
    window_next     = window;
    flags_next      = flags;
    byte_count_next = byte_count;
    emit_mask       = '0;
    tgt_mask        = '0;
    handoff.run.n   = byte_count - CNT_W'(1);
    handoff.run.win = window;
    if (!full) begin
      emit_mask       = last_byte ? flg_new : (flg_new & due);
      tgt_mask        = rip_en ? (flg_new & due) : '0;
      handoff.run.n   = byte_count;
      handoff.run.win = win_sh;
      window_next     = win_sh;
      flags_next      = flg_new & ~emit_mask;
      byte_count_next = byte_count + CNT_W'(1);
    end else if (last_byte) begin
      emit_mask = flags;
    end
    if (last_byte) begin
      window_next     = '0;
      flags_next      = '0;
      byte_count_next = '0;
    end
    handoff.run.mask  = emit_mask;
    handoff.run.tmask = tgt_mask;
    handoff.run.last  = last_byte;
    handoff.load      = accept && (emit_mask != '0);
    handoff.end_empty = accept && last_byte && (emit_mask == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      flags      <= '0;
      byte_count <= '0;
    end else if (accept) begin
      window     <= window_next;
      flags      <= flags_next;
      byte_count <= byte_count_next;
    end
  end

  `MBSS_ASSERT_NEXT(a_stream_clear, clk, rst, accept && last_byte, (flags == '0) && (byte_count == '0))

endmodule

// ===== rtl/core/mbss_seq.sv =====
`timescale 1ns / 1ps
`include "masked_byte_signature_scan_defines.svh"
// ----------------------------------------------------------------------------
// mbss_seq
// walks a byte's matches oldest first, one per ready cycle, and counts them
// ----------------------------------------------------------------------------
module mbss_seq (
  input  logic               clk,
  input  logic               rst,
  input  mbss_pkg::cfg_t     cfg,
  input  mbss_pkg::handoff_t handoff,
  input  logic               pick_ready,
  output logic               run_free,
  output mbss_pkg::pick_t    pick
);
  import mbss_pkg::*;

  run_t               run;
  logic               run_valid;
  logic [MATCH_W-1:0] reported_count;
  logic [MATCH_W-1:0] reported_count_next;

  logic [AGE_W-1:0]  age;
  logic [AGE_W-1:0]  a0;
  flags_t            rest;
  flags_t            trest;
  logic              emit_ok;
  logic              rest_empty;
  logic              fire;
  logic              done;
  logic              ht;
  logic              at_limit;
  logic [DISP_W-1:0] disp_raw;

  // oldest pending match has the highest age
  always_comb begin
    age = '0;
    for (int a = 0; a < WINDOW_DEPTH; a++) begin
      if (run.mask[a]) begin
        age = AGE_W'(a);
      end
    end
    rest       = run.mask;
    rest[age]  = 1'b0;
    trest      = run.tmask;
    trest[age] = 1'b0;
  end

  assign rest_empty = (rest == '0);
  assign emit_ok    = (reported_count < cfg.max_matches);
  assign at_limit   = ({1'b0, reported_count} + (MATCH_W+1)'(1)) == {1'b0, cfg.max_matches};
  assign fire       = run_valid && pick_ready;
  assign done       = fire && (!emit_ok || rest_empty);
  assign run_free   = !run_valid || done;
  assign ht         = run.tmask[age];
  assign a0         = age - rip_value(cfg);

  always_comb begin
    logic [AGE_W-1:0] idx;
    for (int t = 0; t < DISP_BYTES; t++) begin
      idx = a0 - AGE_W'(t);
      disp_raw[8*t +: 8] = (int'(idx) < WINDOW_DEPTH) ? run.win[idx] : 8'h00;
    end
  end

  always_comb begin
    reported_count_next = reported_count;
    if (fire && emit_ok) begin
      reported_count_next = reported_count + MATCH_W'(1);
    end
    if ((done && run.last) || handoff.end_empty) begin
      reported_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid      <= 1'b0;
      reported_count <= '0;
    end else begin
      reported_count <= reported_count_next;
      if (run_free) begin
        run_valid <= handoff.load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_free) begin
      if (handoff.load) begin
        run <= handoff.run;
      end
    end else if (fire) begin
      run.mask  <= rest;
      run.tmask <= trest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pick.valid <= 1'b0;
    end else if (fire) begin
      pick.valid <= emit_ok;
    end else if (pick_ready) begin
      pick.valid <= 1'b0;
    end
    if (fire) begin
      pick.offset     <= run.n - CNT_W'(age);
      pick.has_target <= ht;
      pick.disp       <= ht ? disp_raw : '0;
      pick.last       <= rest_empty || at_limit;
    end
  end

  `MBSS_ASSERT_IMPLY(a_run_nonempty, clk, rst, run_valid, run.mask != '0)
  `MBSS_ASSERT_IMPLY(a_target_subset, clk, rst, run_valid, (run.tmask & ~run.mask) == '0)

endmodule

// ===== rtl/core/mbss_result.sv =====
`timescale 1ns / 1ps
`include "masked_byte_signature_scan_defines.svh"
// ----------------------------------------------------------------------------
// mbss_result
// address and target arithmetic and the output register
// ----------------------------------------------------------------------------
module mbss_result (
  input  logic                          clk,
  input  logic                          rst,
  input  mbss_pkg::cfg_t                cfg,
  input  mbss_pkg::pick_t               pick,
  output logic                          pick_ready,
  output logic                          match_valid,
  input  logic                          match_stall,
  output logic [mbss_pkg::CNT_W-1:0]    match_offset,
  output logic [mbss_pkg::ADDR_W-1:0]   match_address,
  output logic                          has_target,
  output logic signed [mbss_pkg::DISP_W-1:0] displacement,
  output logic [mbss_pkg::ADDR_W-1:0]   target_address,
  output logic                          last_of_run
);
  import mbss_pkg::*;

  logic              q_valid;
  logic [CNT_W-1:0]  q_offset;
  logic [DISP_W-1:0] q_disp;
  logic              q_ht;
  logic              q_last;
  logic [REL_W-1:0]  q_rel;

  logic              out_ready;
  logic              q_ready;
  logic [REL_W-1:0]  rel;

  assign out_ready  = !match_valid || !match_stall;
  assign q_ready    = !q_valid || out_ready;
  assign pick_ready = !pick.valid || q_ready;

  // offset + insn_len + signed displacement, relative to base
  assign rel = {{(REL_W-CNT_W){1'b0}}, pick.offset}
             + {{(REL_W-4){1'b0}}, cfg.insn_len}
             + {{(REL_W-DISP_W){pick.disp[DISP_W-1]}}, pick.disp};

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_ready) begin
      q_valid <= pick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && pick.valid) begin
      q_offset <= pick.offset;
      q_disp   <= pick.disp;
      q_ht     <= pick.has_target;
      q_last   <= pick.last;
      q_rel    <= rel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (out_ready) begin
      match_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && q_valid) begin
      match_offset   <= q_offset;
      match_address  <= cfg.base_address + {{(ADDR_W-CNT_W){1'b0}}, q_offset};
      has_target     <= q_ht;
      displacement   <= q_disp;
      target_address <= q_ht
                        ? cfg.base_address + {{(ADDR_W-REL_W){q_rel[REL_W-1]}}, q_rel}
                        : '0;
      last_of_run    <= q_last;
    end
  end

  `MBSS_ASSERT_IMPLY(a_no_target_zero, clk, rst, match_valid && !has_target, (displacement == '0) && (target_address == '0))

endmodule
